// ===== hw/rtl/assert_macros.svh =====
// assertion helpers shared by the checker files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every clock edge outside reset
`define PSD_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// checked on every clock edge, reset included
`define PSD_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) (prop)) \
    else $error("assertion failed");

`endif

// ===== hw/rtl/psd_pkg.sv =====
// ----------------------------------------------------------------------------
// psd_pkg
// Types and constants shared by the packed symbol distance block.
// ----------------------------------------------------------------------------
package psd_pkg;

  localparam int unsigned WORD_W      = 32;
  localparam int unsigned SLOTS       = 16;  // 2-bit slots in one subword
  localparam int unsigned TERM_W      = 15;  // up to 128*128
  localparam int unsigned DIST_W      = 17;  // up to 4*128*128
  localparam int unsigned SYM_LOG2_W  = 2;
  localparam int unsigned LAST_BITS_W = 5;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 5;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SYMBOL_BITS_LOG2 = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SQUARE_MODE      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LAST_VALID_BITS  = 2'd2;

  // symbol size codes
  localparam logic [SYM_LOG2_W-1:0] SYM_1BIT = 2'd0;
  localparam logic [SYM_LOG2_W-1:0] SYM_2BIT = 2'd1;
  localparam logic [SYM_LOG2_W-1:0] SYM_4BIT = 2'd2;
  localparam logic [SYM_LOG2_W-1:0] SYM_8BIT = 2'd3;

  typedef struct packed {
    logic [SYM_LOG2_W-1:0]  symbol_bits_log2;
    logic                   square_mode;
    logic [LAST_BITS_W-1:0] last_valid_bits;
  } cfg_t;

  typedef struct packed {
    logic [DIST_W-1:0] word_sum;
    logic              last;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

// ===== hw/rtl/psd_front.sv =====
// ----------------------------------------------------------------------------
// psd_front
// Two-stage front end: per-slot lane distances, then an adder tree that
// yields the distance of one subword pair.
// ----------------------------------------------------------------------------
module psd_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         en,
  input  logic                         in_take,
  input  logic [psd_pkg::WORD_W-1:0]   word_a,
  input  logic [psd_pkg::WORD_W-1:0]   word_b,
  input  logic                         is_last,
  input  psd_pkg::cfg_t                cfg,
  output logic                         ent_valid,
  output psd_pkg::entry_t              ent
);

  logic [7:0]                    va     [psd_pkg::SLOTS];
  logic [7:0]                    vb     [psd_pkg::SLOTS];
  logic [psd_pkg::TERM_W-1:0]    term   [psd_pkg::SLOTS];
  logic [psd_pkg::TERM_W-1:0]    term_r [psd_pkg::SLOTS];
  logic [psd_pkg::DIST_W-1:0]    lvl1   [8];
  logic [psd_pkg::DIST_W-1:0]    lvl2   [4];
  logic [psd_pkg::DIST_W-1:0]    lvl3   [2];
  logic [psd_pkg::DIST_W-1:0]    sum;
  logic [psd_pkg::WORD_W-1:0]    xm;
  logic [psd_pkg::WORD_W-1:0]    keep;
  logic [7:0]                    lmask;
  logic                          s1_valid_r, s1_valid_nxt;
  logic                          s1_last_r;
  logic                          s2_valid_r, s2_valid_nxt;
  psd_pkg::entry_t               s2_ent_r;

  function automatic logic [7:0] circ_dist(input logic [7:0] a, input logic [7:0] b,
                                           input logic [7:0] m);
    logic [7:0] d1;
    logic [7:0] d2;
    d1 = (a - b) & m;
    d2 = (b - a) & m;
    return (d1 <= d2) ? d1 : d2;
  endfunction

  // slot k of the subword holds one lane (or a pair of 1-bit lanes)
  always_comb begin
    keep = '1;
    if (is_last && cfg.last_valid_bits != '0) begin
      keep = ~({psd_pkg::WORD_W{1'b1}} << cfg.last_valid_bits);
    end
    xm = (word_a ^ word_b) & keep;
    for (int k = 0; k < psd_pkg::SLOTS; k++) begin
      va[k] = '0;
      vb[k] = '0;
    end
    lmask = 8'h00;
    case (cfg.symbol_bits_log2)
      psd_pkg::SYM_2BIT: begin
        lmask = 8'h03;
        for (int k = 0; k < 16; k++) begin
          va[k] = {6'd0, word_a[2*k +: 2]};
          vb[k] = {6'd0, word_b[2*k +: 2]};
        end
      end
      psd_pkg::SYM_4BIT: begin
        lmask = 8'h0F;
        for (int k = 0; k < 8; k++) begin
          va[k] = {4'd0, word_a[4*k +: 4]};
          vb[k] = {4'd0, word_b[4*k +: 4]};
        end
      end
      psd_pkg::SYM_8BIT: begin
        lmask = 8'hFF;
        for (int k = 0; k < 4; k++) begin
          va[k] = word_a[8*k +: 8];
          vb[k] = word_b[8*k +: 8];
        end
      end
      default: begin
        lmask = 8'h00;
      end
    endcase
    for (int k = 0; k < psd_pkg::SLOTS; k++) begin
      logic [7:0]  d;
      logic [15:0] sq;
      d  = circ_dist(va[k], vb[k], lmask);
      sq = d * d;
      if (cfg.symbol_bits_log2 == psd_pkg::SYM_1BIT) begin
        term[k] = psd_pkg::TERM_W'({1'b0, xm[2*k]} + {1'b0, xm[2*k+1]});
      end else if (cfg.square_mode) begin
        term[k] = sq[psd_pkg::TERM_W-1:0];
      end else begin
        term[k] = psd_pkg::TERM_W'(d);
      end
    end
  end

  always_comb begin
    for (int k = 0; k < 8; k++) begin
      lvl1[k] = psd_pkg::DIST_W'(term_r[2*k]) + psd_pkg::DIST_W'(term_r[2*k+1]);
    end
    for (int k = 0; k < 4; k++) begin
      lvl2[k] = lvl1[2*k] + lvl1[2*k+1];
    end
    for (int k = 0; k < 2; k++) begin
      lvl3[k] = lvl2[2*k] + lvl2[2*k+1];
    end
    sum = lvl3[0] + lvl3[1];
  end

  assign s1_valid_nxt = en ? in_take : s1_valid_r;
  assign s2_valid_nxt = en ? s1_valid_r : s2_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      s2_valid_r <= s2_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < psd_pkg::SLOTS; k++) begin
        term_r[k] <= term[k];
      end
      s1_last_r         <= is_last;
      s2_ent_r.word_sum <= sum;
      s2_ent_r.last     <= s1_last_r;
    end
  end

  assign ent_valid = s2_valid_r;
  assign ent       = s2_ent_r;

endmodule

// ===== hw/rtl/psd_queue.sv =====
// ----------------------------------------------------------------------------
// psd_queue
// Small register queue between the front end and the accumulator.
// ----------------------------------------------------------------------------
module psd_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  psd_pkg::entry_t   push_ent,
  input  logic              pop,
  output psd_pkg::entry_t   head,
  output psd_pkg::q_stat_t  stat
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  psd_pkg::entry_t     mem_r [DEPTH];
  logic [PTR_W-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic                do_push;
  logic                do_pop;

  assign stat.full  = (count_r == CNT_W'(DEPTH));
  assign stat.empty = (count_r == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_ent;
    end
  end

  assign head = mem_r[rd_ptr_r];

endmodule

// ===== hw/rtl/psd_back.sv =====
// ----------------------------------------------------------------------------
// psd_back
// Saturating accumulator and result register.
// ----------------------------------------------------------------------------
module psd_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  psd_pkg::q_stat_t            q_stat,
  input  psd_pkg::entry_t             q_head,
  output logic                        q_pop,
  input  logic                        res_pop,
  output logic                        res_valid,
  output logic [psd_pkg::WORD_W-1:0]  res_distance
);

  logic [psd_pkg::WORD_W-1:0] total_r, total_nxt;
  logic [psd_pkg::WORD_W-1:0] res_r;
  logic                       res_valid_r, res_valid_nxt;
  logic [psd_pkg::WORD_W:0]   wide;
  logic [psd_pkg::WORD_W-1:0] sat;
  logic                       res_taken;

  assign res_taken = res_pop && res_valid_r;
  // a closing beat needs a free result register
  assign q_pop = !q_stat.empty && (!q_head.last || !res_valid_r || res_taken);

  assign wide = {1'b0, total_r} + (psd_pkg::WORD_W + 1)'(q_head.word_sum);
  assign sat  = wide[psd_pkg::WORD_W] ? '1 : wide[psd_pkg::WORD_W-1:0];

  always_comb begin
    total_nxt     = total_r;
    res_valid_nxt = res_valid_r && !res_taken;
    if (q_pop) begin
      total_nxt = q_head.last ? '0 : sat;
      if (q_head.last) begin
        res_valid_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r     <= '0;
      res_valid_r <= 1'b0;
    end else begin
      total_r     <= total_nxt;
      res_valid_r <= res_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && q_head.last) begin
      res_r <= sat;
    end
  end

  assign res_valid    = res_valid_r;
  assign res_distance = res_r;

endmodule

// ===== hw/rtl/packed_symbol_distance.sv =====
// ----------------------------------------------------------------------------
// packed_symbol_distance
// Hamming / circular symbol distance over streamed subword pairs.
// ----------------------------------------------------------------------------
// Input queue side: drive in_word_a/in_word_b/in_is_last with in_push; a beat
// is taken when in_push is high and in_full is low. Result queue side: while
// out_empty is low, out_distance holds the oldest result; out_pop takes it.
// Only a beat with in_is_last set produces a result, the saturated total of
// all subword distances since the previous result.
// Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data, always
// ready; write it only while the block is idle.
// Throughput: one subword pair per cycle while in_full is low. A closing beat
// reaches the result ports through the second front stage, the entry queue
// and the result register in turn; it waits while a result stays unpopped.
// When the receiver stalls, results back up into the accumulator, then the
// entry queue, then the front stages, and in_full rises; nothing is dropped.
// Reset clears all pipeline valids, the queue and the running total, and
// sets the registers to 1-bit symbols, square mode on, all bits valid.
// ----------------------------------------------------------------------------
module packed_symbol_distance #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_push,
  output logic                             in_full,
  input  logic [31:0]                      in_word_a,
  input  logic [31:0]                      in_word_b,
  input  logic                             in_is_last,
  output logic                             out_empty,
  input  logic                             out_pop,
  output logic [31:0]                      out_distance,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [psd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [psd_pkg::CFG_DATA_W-1:0]   cfg_data
);

  psd_pkg::cfg_t    cfg_r, cfg_nxt;
  psd_pkg::entry_t  ent;
  psd_pkg::entry_t  head;
  psd_pkg::q_stat_t q_stat;
  logic             ent_valid;
  logic             en;
  logic             q_pop;
  logic             res_valid;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_index)
        psd_pkg::CFG_SYMBOL_BITS_LOG2: begin
          cfg_nxt.symbol_bits_log2 = cfg_data[psd_pkg::SYM_LOG2_W-1:0];
        end
        psd_pkg::CFG_SQUARE_MODE: begin
          cfg_nxt.square_mode = cfg_data[0];
        end
        psd_pkg::CFG_LAST_VALID_BITS: begin
          cfg_nxt.last_valid_bits = cfg_data[psd_pkg::LAST_BITS_W-1:0];
        end
        default: begin
          cfg_nxt = cfg_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.symbol_bits_log2 <= psd_pkg::SYM_1BIT;
      cfg_r.square_mode      <= 1'b1;
      cfg_r.last_valid_bits  <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // front stages move together unless an entry waits on a full entry queue
  assign en      = !(ent_valid && q_stat.full);
  assign in_full = !en;

  psd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_take   (in_push && en),
    .word_a    (in_word_a),
    .word_b    (in_word_b),
    .is_last   (in_is_last),
    .cfg       (cfg_r),
    .ent_valid (ent_valid),
    .ent       (ent)
  );

  psd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (ent_valid),
    .push_ent (ent),
    .pop      (q_pop),
    .head     (head),
    .stat     (q_stat)
  );

  psd_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_stat       (q_stat),
    .q_head       (head),
    .q_pop        (q_pop),
    .res_pop      (out_pop),
    .res_valid    (res_valid),
    .res_distance (out_distance)
  );

  assign out_empty = !res_valid;

endmodule

// ===== hw/rtl/psd_checker.sv =====
// ----------------------------------------------------------------------------
// psd_checker
// Port-level checks for packed_symbol_distance, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module psd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_full,
  input logic        out_empty,
  input logic        out_pop,
  input logic [31:0] out_distance
);

  // both queues come out of reset empty and open
  `PSD_ASSERT_ALWAYS(a_reset_state, clk, !rst_n |=> (out_empty && !in_full))

  // a waiting result that is not popped stays put
  `PSD_ASSERT(a_result_holds, clk, rst_n,
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_distance)))

  // with the result side empty the accumulator drains, so full never lingers
  `PSD_ASSERT(a_full_releases, clk, rst_n, (in_full && out_empty) |=> !in_full)

endmodule

bind packed_symbol_distance psd_checker u_psd_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_full      (in_full),
  .out_empty    (out_empty),
  .out_pop      (out_pop),
  .out_distance (out_distance)
);

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for packed_symbol_distance: subword pairs are pushed
// under random idling and backpressure, a scoreboard class predicts every
// closing distance and checks the popped results in order.
// ----------------------------------------------------------------------------
module tb;

  class distance_tracker;
    logic [psd_pkg::SYM_LOG2_W-1:0]  sym_log2;
    logic                            square_on;
    logic [psd_pkg::LAST_BITS_W-1:0] tail_bits;
    bit [31:0]                       running;
    bit [31:0]                       expected_distances[$];
    int                              errors;
    int                              vectors;
    int                              beats;

    function new();
      sym_log2  = psd_pkg::SYM_1BIT;
      square_on = 1'b1;
      tail_bits = '0;
      running   = '0;
      errors    = 0;
      vectors   = 0;
      beats     = 0;
    endfunction

    function void write_reg(logic [psd_pkg::CFG_IDX_W-1:0] idx,
                            logic [psd_pkg::CFG_DATA_W-1:0] val);
      case (idx)
        psd_pkg::CFG_SYMBOL_BITS_LOG2: sym_log2  = val[psd_pkg::SYM_LOG2_W-1:0];
        psd_pkg::CFG_SQUARE_MODE:      square_on = val[0];
        psd_pkg::CFG_LAST_VALID_BITS:  tail_bits = val[psd_pkg::LAST_BITS_W-1:0];
        default: ;
      endcase
    endfunction

    function bit [31:0] word_distance(bit [31:0] a, bit [31:0] b, bit last);
      bit [31:0] x;
      bit [31:0] acc;
      bit [31:0] dw;
      bit [7:0]  lmask;
      bit [7:0]  va;
      bit [7:0]  vb;
      bit [7:0]  d1;
      bit [7:0]  d2;
      int        width;
      int        sh;
      if (sym_log2 == psd_pkg::SYM_1BIT) begin
        x = a ^ b;
        if (last && tail_bits != 0)
          x &= (32'd1 << tail_bits) - 32'd1;
        return $countones(x);
      end
      width = 1 << sym_log2;
      lmask = 8'((1 << width) - 1);
      acc   = '0;
      for (int j = 0; j < 32 / width; j++) begin
        // lanes are packed from the top down
        sh = 32 - (j + 1) * width;
        va = 8'(a >> sh) & lmask;
        vb = 8'(b >> sh) & lmask;
        d1 = (va - vb) & lmask;
        d2 = (vb - va) & lmask;
        dw = (d1 <= d2) ? d1 : d2;
        acc += square_on ? dw * dw : dw;
      end
      return acc;
    endfunction

    function void note_beat(bit [31:0] a, bit [31:0] b, bit last);
      bit [32:0] t;
      beats++;
      t = {1'b0, running} + {1'b0, word_distance(a, b, last)};
      running = t[32] ? 32'hFFFF_FFFF : t[31:0];
      if (last) begin
        expected_distances.insert(expected_distances.size(), running);
        running = '0;
      end
    endfunction

    function void check_result(logic [31:0] got);
      bit [31:0] want;
      if (expected_distances.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: result %08h with nothing expected", got);
        return;
      end
      want = expected_distances.pop_front();
      vectors++;
      if (got !== want) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: distance expected %08h actual %08h", want, got);
      end
    endfunction
  endclass

  logic                           clk;
  logic                           rst_n;
  logic                           in_push;
  logic                           in_full;
  logic [31:0]                    in_word_a;
  logic [31:0]                    in_word_b;
  logic                           in_is_last;
  logic                           out_empty;
  logic                           out_pop;
  logic [31:0]                    out_distance;
  logic                           cfg_valid;
  logic                           cfg_ready;
  logic [psd_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [psd_pkg::CFG_DATA_W-1:0] cfg_data;

  distance_tracker sb = new();
  int send_idle_pct = 33;
  int recv_idle_pct = 64;
  int hold_left     = 0;
  int settings      = 0;

  packed_symbol_distance DUT (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_push      (in_push),
    .in_full      (in_full),
    .in_word_a    (in_word_a),
    .in_word_b    (in_word_b),
    .in_is_last   (in_is_last),
    .out_empty    (out_empty),
    .out_pop      (out_pop),
    .out_distance (out_distance),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("tb: errors");
    $finish;
  end

  // result side: pop at random, with an optional long hold-off
  initial begin
    out_pop <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_pop && !out_empty)
        sb.check_result(out_distance);
      if (hold_left > 0) begin
        out_pop <= 1'b0;
        hold_left--;
      end else begin
        out_pop <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  task automatic send_beat(input bit [31:0] a, input bit [31:0] b, input bit last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
    in_push    <= 1'b1;
    in_word_a  <= a;
    in_word_b  <= b;
    in_is_last <= last;
    @(posedge clk);
    while (in_full) @(posedge clk);
    sb.note_beat(a, b, last);
  endtask

  task automatic write_reg(input logic [psd_pkg::CFG_IDX_W-1:0] idx,
                           input logic [psd_pkg::CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_reg(idx, val);
  endtask

  task automatic write_config(input logic [1:0] sym, input logic sq, input logic [4:0] tail);
    write_reg(psd_pkg::CFG_SYMBOL_BITS_LOG2, {3'b000, sym});
    write_reg(psd_pkg::CFG_SQUARE_MODE, {4'b0000, sq});
    write_reg(psd_pkg::CFG_LAST_VALID_BITS, tail);
    cfg_valid <= 1'b0;
    settings++;
  endtask

  // stop pushing until every closing beat has come back, then let the
  // pipeline settle so that no open vector is still in flight
  task automatic drain();
    in_push <= 1'b0;
    while (sb.expected_distances.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  function automatic void pick_words(output bit [31:0] a, output bit [31:0] b);
    int style;
    style = $urandom_range(9);
    a = $urandom;
    case (style)
      0: b = a ^ (32'd1 << $urandom_range(31));
      1: b = a;
      2: begin
        a = $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0;
        b = $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0;
      end
      3: b = a + 32'($urandom_range(3)) - 32'd1;
      default: b = $urandom;
    endcase
  endfunction

  initial begin
    bit [31:0]  a;
    bit [31:0]  b;
    int         len;
    int         sent;
    logic [1:0] sym;
    logic       sq;
    logic [4:0] tail;

    rst_n      <= 1'b0;
    in_push    <= 1'b0;
    in_word_a  <= '0;
    in_word_b  <= '0;
    in_is_last <= 1'b0;
    cfg_valid  <= 1'b0;
    cfg_index  <= '0;
    cfg_data   <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: 1-bit symbols, all bits valid
    send_beat(32'h0, 32'h0, 1'b1);
    send_beat(32'hFFFF_FFFF, 32'h0, 1'b1);
    send_beat(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
    send_beat(32'hFFFF_FFFF, 32'h0, 1'b0);
    send_beat(32'h1, 32'h0, 1'b1);
    drain();

    // tail mask on the closing subword only
    write_config(psd_pkg::SYM_1BIT, 1'b0, 5'd31);
    send_beat(32'hFFFF_FFFF, 32'h0, 1'b0);
    send_beat(32'hFFFF_FFFF, 32'h0, 1'b1);
    send_beat(32'h8000_0000, 32'h0, 1'b1);
    drain();
    write_config(psd_pkg::SYM_1BIT, 1'b1, 5'd1);
    send_beat(32'hFFFF_FFFE, 32'h0, 1'b1);
    send_beat(32'h3, 32'h0, 1'b1);
    drain();

    // wider symbols, circular wrap and the tail mask ignored
    write_config(psd_pkg::SYM_2BIT, 1'b1, 5'd7);
    send_beat(32'h0, 32'hAAAA_AAAA, 1'b1);
    send_beat(32'h5555_5555, 32'hFFFF_FFFF, 1'b0);
    send_beat(32'h0, 32'h5555_5555, 1'b1);
    drain();
    write_config(psd_pkg::SYM_4BIT, 1'b0, 5'd0);
    send_beat(32'h0F0F_0F0F, 32'hF0F0_F0F0, 1'b1);
    send_beat(32'hFFFF_FFFF, 32'h0, 1'b0);
    send_beat(32'h8765_4321, 32'h1234_5678, 1'b1);
    drain();
    write_config(psd_pkg::SYM_8BIT, 1'b1, 5'd5);
    send_beat(32'h80FF_0001, 32'h0001_7F00, 1'b1);
    send_beat(32'h8080_8080, 32'h0, 1'b1);
    send_beat(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
    drain();
    write_config(psd_pkg::SYM_8BIT, 1'b0, 5'd31);
    send_beat(32'h7F80_7F80, 32'h0, 1'b1);
    send_beat(32'h0, 32'h8080_8080, 1'b1);
    drain();

    // a vector of maximal squared lanes builds a large total,
    // the next vector must start from zero again
    write_config(psd_pkg::SYM_8BIT, 1'b1, 5'd0);
    for (int i = 0; i < 15; i++)
      send_beat(32'h8080_8080, 32'h0, 1'b0);
    send_beat(32'h8080_8080, 32'h0, 1'b1);
    send_beat(32'h0, 32'h0, 1'b1);
    drain();

    for (int phase = 0; phase < 12; phase++) begin
      if (phase < 4) begin
        send_idle_pct = 33;
        recv_idle_pct = 64;
      end else if (phase < 8) begin
        send_idle_pct = 64;
        recv_idle_pct = 33;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      case (phase)
        0: begin sym = psd_pkg::SYM_1BIT; sq = 1'b0; tail = 5'd0;  end
        1: begin sym = psd_pkg::SYM_1BIT; sq = 1'b1; tail = 5'd31; end
        2: begin sym = psd_pkg::SYM_2BIT; sq = 1'b0; tail = 5'd31; end
        3: begin sym = psd_pkg::SYM_4BIT; sq = 1'b1; tail = 5'd0;  end
        4: begin sym = psd_pkg::SYM_8BIT; sq = 1'b0; tail = 5'd0;  end
        5: begin sym = psd_pkg::SYM_8BIT; sq = 1'b1; tail = 5'd31; end
        default: begin
          sym  = 2'($urandom_range(3));
          sq   = 1'($urandom_range(1));
          tail = 5'($urandom_range(31));
        end
      endcase
      write_config(sym, sq, tail);
      // receiver goes deaf while single-beat vectors keep coming
      if (phase == 10)
        hold_left = 400;
      sent = 0;
      while (sent < 60) begin
        if (phase == 10)
          len = 1;
        else if ($urandom_range(99) < 75)
          len = $urandom_range(4, 1);
        else
          len = $urandom_range(12, 5);
        for (int i = 0; i < len; i++) begin
          pick_words(a, b);
          send_beat(a, b, i == len - 1);
        end
        sent += len;
      end
      drain();
    end

    in_push <= 1'b0;
    while (sb.expected_distances.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("summary: %0d beats, %0d distances compared, %0d register settings",
             sb.beats, sb.vectors, settings);
    $display("summary: 1/2/4/8-bit symbols, square and plain sums, tail masks, %s",
             "large totals, full-queue backpressure");
    if (sb.errors == 0 && sb.expected_distances.size() == 0) begin
      $display("tb: clean");
    end else begin
      $display("mismatches: %0d", sb.errors);
      $display("tb: errors");
    end
    $finish;
  end

endmodule

// ===== packed_symbol_distance.f =====
+incdir+hw/rtl
hw/rtl/psd_pkg.sv
hw/rtl/psd_front.sv
hw/rtl/psd_queue.sv
hw/rtl/psd_back.sv
hw/rtl/packed_symbol_distance.sv
hw/rtl/psd_checker.sv
bench/tb.sv
